### rtl/core/idll_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store for the indexed doubly linked list.
// Depends on nothing; every other file in rtl/core imports it.

package idll_pkg;

  localparam int NodeCount = 256;
  localparam int IdxW      = $clog2(NodeCount);
  localparam int LinkW     = $clog2(NodeCount + 1);
  localparam int StepW     = 6;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [LinkW-1:0] link_t;
  typedef logic [StepW-1:0] step_t;

  // Link value that means "no node".
  localparam link_t NoNode = link_t'(NodeCount);

  typedef enum logic [2:0] {
    CMD_PUSH_HEAD = 3'd0,
    CMD_PUSH_TAIL = 3'd1,
    CMD_POP_HEAD  = 3'd2,
    CMD_POP_TAIL  = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_MOVE_HEAD = 3'd5,
    CMD_MOVE_TAIL = 3'd6,
    CMD_REBUILD   = 3'd7
  } cmd_e;

  // Control store addresses.
  localparam step_t S_IDLE    = step_t'(0);
  localparam step_t S_PH0     = step_t'(1);
  localparam step_t S_PH1     = step_t'(2);
  localparam step_t S_PH2     = step_t'(3);
  localparam step_t S_PH3     = step_t'(4);
  localparam step_t S_PT0     = step_t'(5);
  localparam step_t S_PT1     = step_t'(6);
  localparam step_t S_PT2     = step_t'(7);
  localparam step_t S_PT3     = step_t'(8);
  localparam step_t S_PUSH_E  = step_t'(9);
  localparam step_t S_POPH0   = step_t'(10);
  localparam step_t S_POPH1   = step_t'(11);
  localparam step_t S_POPH2   = step_t'(12);
  localparam step_t S_POPH_L  = step_t'(13);
  localparam step_t S_POPT0   = step_t'(14);
  localparam step_t S_POPT1   = step_t'(15);
  localparam step_t S_POPT2   = step_t'(16);
  localparam step_t S_POPT_L  = step_t'(17);
  localparam step_t S_RM0     = step_t'(18);
  localparam step_t S_RM1     = step_t'(19);
  localparam step_t S_RM1A    = step_t'(20);
  localparam step_t S_RM1B    = step_t'(21);
  localparam step_t S_RM2     = step_t'(22);
  localparam step_t S_RM2A    = step_t'(23);
  localparam step_t S_RM2B    = step_t'(24);
  localparam step_t S_RM_DONE = step_t'(25);
  localparam step_t S_MV_H    = step_t'(26);
  localparam step_t S_MV_T    = step_t'(27);
  localparam step_t S_EMPTY   = step_t'(28);
  localparam step_t S_RB0     = step_t'(29);
  localparam step_t S_RB1     = step_t'(30);
  localparam step_t S_RB2     = step_t'(31);
  localparam step_t S_RESP    = step_t'(32);

  typedef enum logic [1:0] {K_RUN, K_DISPATCH, K_RESPOND} kind_e;

  typedef enum logic [3:0] {
    C_ALWAYS, C_EMPTY_H, C_EMPTY_T, C_HEAD_EQ_N, C_TAIL_EQ_N, C_P_IN, C_X_IN,
    C_CNT_ZERO, C_IS_MOVE, C_MOVE_HEAD, C_IDX_LAST, C_INIT
  } cond_e;

  typedef enum logic [1:0] {RS_NODE, RS_HEAD, RS_TAIL} rsel_e;

  typedef enum logic [2:0] {WA_NODE, WA_HEAD, WA_TAIL, WA_RDP, WA_RDN, WA_IDX} wa_e;

  typedef enum logic [2:0] {
    WD_NONE, WD_NODE, WD_HEAD, WD_TAIL, WD_RDP, WD_RDN, WD_CHAIN
  } wd_e;

  typedef enum logic [2:0] {PS_KEEP, PS_NODE, PS_RDP, PS_RDN, PS_NONE, PS_CHAIN} psel_e;

  typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC, CNT_LOAD} cnt_e;

  typedef enum logic [1:0] {POP_NONE, POP_HEAD, POP_TAIL} pop_e;

  typedef struct packed {
    kind_e kind;
    cond_e cond;
    logic  cond_inv;
    step_t target;
    logic  rd_en;
    rsel_e rsel;
    logic  prev_we;
    wa_e   prev_wa;
    wd_e   prev_wd;
    logic  next_we;
    wa_e   next_wa;
    wd_e   next_wd;
    psel_e head_sel;
    psel_e tail_sel;
    cnt_e  cnt_op;
    logic  st_set;
    pop_e  pop_sel;
    logic  rb_start;
    logic  idx_inc;
    logic  init_clr;
  } ucode_t;

  // One write request to a link memory.
  typedef struct packed {
    logic  we;
    idx_t  addr;
    link_t data;
  } link_wr_t;

  // A never-taken jump falls through to the next step; nothing else happens.
  localparam ucode_t UcNop = '{
    kind: K_RUN, cond: C_ALWAYS, cond_inv: 1'b1, target: S_IDLE,
    rd_en: 1'b0, rsel: RS_NODE,
    prev_we: 1'b0, prev_wa: WA_NODE, prev_wd: WD_NONE,
    next_we: 1'b0, next_wa: WA_NODE, next_wd: WD_NONE,
    head_sel: PS_KEEP, tail_sel: PS_KEEP, cnt_op: CNT_KEEP,
    st_set: 1'b0, pop_sel: POP_NONE, rb_start: 1'b0, idx_inc: 1'b0, init_clr: 1'b0
  };

  function automatic logic in_pool(input link_t x);
    return x < NoNode;
  endfunction

  function automatic step_t dispatch(input cmd_e cmd, input logic node_ok);
    step_t s;
    case (cmd)
      CMD_PUSH_HEAD: s = node_ok ? S_PH0 : S_RESP;
      CMD_PUSH_TAIL: s = node_ok ? S_PT0 : S_RESP;
      CMD_POP_HEAD:  s = S_POPH0;
      CMD_POP_TAIL:  s = S_POPT0;
      CMD_REMOVE:    s = node_ok ? S_RM0 : S_RESP;
      CMD_MOVE_HEAD: s = node_ok ? S_RM0 : S_RESP;
      CMD_MOVE_TAIL: s = node_ok ? S_RM0 : S_RESP;
      CMD_REBUILD:   s = S_RB0;
      default:       s = S_RESP;
    endcase
    return s;
  endfunction

  // The control store.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = UcNop;
    case (step)
      S_IDLE: begin
        w.kind = K_DISPATCH;
      end
      // Push at head.
      S_PH0: begin
        w.cond = C_EMPTY_H; w.cond_inv = 1'b0; w.target = S_PUSH_E;
      end
      S_PH1: begin
        w.cond = C_HEAD_EQ_N; w.cond_inv = 1'b0; w.target = S_RESP;
      end
      S_PH2: begin
        w.prev_we = 1'b1; w.prev_wa = WA_NODE; w.prev_wd = WD_NONE;
        w.next_we = 1'b1; w.next_wa = WA_NODE; w.next_wd = WD_HEAD;
      end
      S_PH3: begin
        w.prev_we = 1'b1; w.prev_wa = WA_HEAD; w.prev_wd = WD_NODE;
        w.head_sel = PS_NODE; w.cnt_op = CNT_INC;
        w.cond_inv = 1'b0; w.target = S_RESP;
      end
      // Push at tail.
      S_PT0: begin
        w.cond = C_EMPTY_T; w.cond_inv = 1'b0; w.target = S_PUSH_E;
      end
      S_PT1: begin
        w.cond = C_TAIL_EQ_N; w.cond_inv = 1'b0; w.target = S_RESP;
      end
      S_PT2: begin
        w.next_we = 1'b1; w.next_wa = WA_NODE; w.next_wd = WD_NONE;
        w.prev_we = 1'b1; w.prev_wa = WA_NODE; w.prev_wd = WD_TAIL;
      end
      S_PT3: begin
        w.next_we = 1'b1; w.next_wa = WA_TAIL; w.next_wd = WD_NODE;
        w.tail_sel = PS_NODE; w.cnt_op = CNT_INC;
        w.cond_inv = 1'b0; w.target = S_RESP;
      end
      S_PUSH_E: begin
        w.prev_we = 1'b1; w.prev_wa = WA_NODE; w.prev_wd = WD_NONE;
        w.next_we = 1'b1; w.next_wa = WA_NODE; w.next_wd = WD_NONE;
        w.head_sel = PS_NODE; w.tail_sel = PS_NODE; w.cnt_op = CNT_INC;
        w.cond_inv = 1'b0; w.target = S_RESP;
      end
      // Pop at head.
      S_POPH0: begin
        w.rd_en = 1'b1; w.rsel = RS_HEAD;
        w.cond = C_EMPTY_H; w.cond_inv = 1'b0; w.target = S_EMPTY;
      end
      S_POPH1: begin
        w.cond = C_X_IN; w.target = S_POPH_L;
      end
      S_POPH2: begin
        w.prev_we = 1'b1; w.prev_wa = WA_RDN; w.prev_wd = WD_NONE;
        w.head_sel = PS_RDN; w.cnt_op = CNT_DEC; w.pop_sel = POP_HEAD;
        w.cond_inv = 1'b0; w.target = S_RESP;
      end
      S_POPH_L: begin
        w.head_sel = PS_NONE; w.tail_sel = PS_NONE; w.cnt_op = CNT_DEC;
        w.pop_sel = POP_HEAD; w.cond_inv = 1'b0; w.target = S_RESP;
      end
      // Pop at tail.
      S_POPT0: begin
        w.rd_en = 1'b1; w.rsel = RS_TAIL;
        w.cond = C_EMPTY_T; w.cond_inv = 1'b0; w.target = S_EMPTY;
      end
      S_POPT1: begin
        w.cond = C_P_IN; w.target = S_POPT_L;
      end
      S_POPT2: begin
        w.next_we = 1'b1; w.next_wa = WA_RDP; w.next_wd = WD_NONE;
        w.tail_sel = PS_RDP; w.cnt_op = CNT_DEC; w.pop_sel = POP_TAIL;
        w.cond_inv = 1'b0; w.target = S_RESP;
      end
      S_POPT_L: begin
        w.head_sel = PS_NONE; w.tail_sel = PS_NONE; w.cnt_op = CNT_DEC;
        w.pop_sel = POP_TAIL; w.cond_inv = 1'b0; w.target = S_RESP;
      end
      // Remove, also the first half of a move.
      S_RM0: begin
        w.rd_en = 1'b1; w.rsel = RS_NODE;
        w.cond = C_CNT_ZERO; w.cond_inv = 1'b0; w.target = S_EMPTY;
      end
      S_RM1: begin
        w.cond = C_P_IN; w.target = S_RM1B;
      end
      S_RM1A: begin
        w.next_we = 1'b1; w.next_wa = WA_RDP; w.next_wd = WD_RDN;
        w.cond_inv = 1'b0; w.target = S_RM2;
      end
      S_RM1B: begin
        w.head_sel = PS_RDN;
      end
      S_RM2: begin
        w.cond = C_X_IN; w.target = S_RM2B;
      end
      S_RM2A: begin
        w.prev_we = 1'b1; w.prev_wa = WA_RDN; w.prev_wd = WD_RDP;
        w.cnt_op = CNT_DEC; w.cond_inv = 1'b0; w.target = S_RM_DONE;
      end
      S_RM2B: begin
        w.tail_sel = PS_RDP; w.cnt_op = CNT_DEC;
      end
      S_RM_DONE: begin
        w.cond = C_IS_MOVE; w.target = S_RESP;
      end
      S_MV_H: begin
        w.cond = C_MOVE_HEAD; w.cond_inv = 1'b0; w.target = S_PH0;
      end
      S_MV_T: begin
        w.cond_inv = 1'b0; w.target = S_PT0;
      end
      S_EMPTY: begin
        w.st_set = 1'b1; w.cond_inv = 1'b0; w.target = S_RM_DONE;
      end
      // Rebuild: one node per cycle.
      S_RB0: begin
        w.rb_start = 1'b1;
      end
      S_RB1: begin
        w.prev_we = 1'b1; w.prev_wa = WA_IDX; w.prev_wd = WD_CHAIN;
        w.next_we = 1'b1; w.next_wa = WA_IDX; w.next_wd = WD_CHAIN;
        w.idx_inc = 1'b1; w.cond = C_IDX_LAST; w.target = S_RB1;
      end
      S_RB2: begin
        w.head_sel = PS_CHAIN; w.tail_sel = PS_CHAIN; w.cnt_op = CNT_LOAD;
        w.init_clr = 1'b1; w.cond = C_INIT; w.cond_inv = 1'b0; w.target = S_IDLE;
      end
      S_RESP: begin
        w.kind = K_RESPOND;
      end
      default: begin
        w.cond_inv = 1'b0; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/idll_link_mem.sv
`timescale 1ns / 1ps
// Previous and next link memories: one write port each, a shared registered read.
// Depends on idll_pkg.

module idll_link_mem import idll_pkg::*; (
  input  logic     clk_i,
  input  link_wr_t prev_wr_i,
  input  link_wr_t next_wr_i,
  input  logic     rd_en_i,
  input  idx_t     rd_addr_i,
  output link_t    prev_rd_o,
  output link_t    next_rd_o
);

  link_t prev_mem [NodeCount];
  link_t next_mem [NodeCount];
  link_t prev_rd_q;
  link_t next_rd_q;

  always_ff @(posedge clk_i) begin
    if (prev_wr_i.we) begin
      prev_mem[prev_wr_i.addr] <= prev_wr_i.data;
    end
    if (rd_en_i) begin
      prev_rd_q <= prev_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_wr_i.we) begin
      next_mem[next_wr_i.addr] <= next_wr_i.data;
    end
    if (rd_en_i) begin
      next_rd_q <= next_mem[rd_addr_i];
    end
  end

  assign prev_rd_o = prev_rd_q;
  assign next_rd_o = next_rd_q;

endmodule

### rtl/core/indexed_doubly_linked_list.sv
`timescale 1ns / 1ps
// Indexed doubly linked list over a pool of NodeCount nodes, run by a microcoded sequencer.
// Depends on idll_pkg and idll_link_mem.
//
//   Channel   Signals                                    Moves
//   in        in_valid_i / in_ready_o                    command_i, node_index_i
//   out       out_valid_o / out_ready_i                  status, popped node, length, ends
//   cfg       cfg_valid_i / cfg_ready_o                  initial_length_i
//
// Requests: one at a time. A push, pop, remove or move runs its own steps of the control
// store, and a rebuild steps through every node. The step counts come from the single
// write port of each link memory and the registered read of a node's links.
// Reset: after rst_ni rises the sequencer sweeps both link memories, one entry per cycle,
// and takes no request meanwhile; configuration writes are taken.
// Stalls: a finished result waits in the output register while the next request is
// accepted and worked on; only the response step of that next request waits for it.

module indexed_doubly_linked_list import idll_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  // Request channel.
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  [2:0] command_i,
  input  idx_t  node_index_i,
  // Result channel.
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  status_o,
  output idx_t  popped_node_o,
  output logic  popped_valid_o,
  output link_t list_length_o,
  output link_t head_node_o,
  output link_t tail_node_o,
  // Configuration channel.
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  link_t initial_length_i
);

  // Sequencer state.
  step_t  step_q, step_d;
  logic   init_q;
  ucode_t uc;
  logic   cond_raw;
  logic   take_jump;
  logic   in_accept;
  logic   resp_fire;

  // List state and per-request working registers.
  link_t  cfg_len_q;
  link_t  head_q, head_d;
  link_t  tail_q, tail_d;
  link_t  cnt_q, cnt_d;
  link_t  len_q;
  idx_t   idx_q;
  cmd_e   cmd_q;
  idx_t   node_q;
  logic   status_q;
  idx_t   pop_q;
  logic   popv_q;

  // Output register.
  logic   out_valid_q;
  logic   out_status_q;
  idx_t   out_pop_q;
  logic   out_popv_q;
  link_t  out_len_q;
  link_t  out_head_q;
  link_t  out_tail_q;

  // Link memory interface.
  link_wr_t prev_wr;
  link_wr_t next_wr;
  idx_t     rd_addr;
  link_t    rdp;
  link_t    rdn;
  link_t    prev_waddr;
  link_t    next_waddr;

  // Derived values.
  link_t  node_ext;
  link_t  idx_ext;
  link_t  idx_plus;
  link_t  chain_prev;
  link_t  chain_next;
  link_t  cfg_len_clip;

  assign uc        = ucode_rom(step_q);
  assign node_ext  = link_t'(node_q);
  assign idx_ext   = link_t'(idx_q);
  assign idx_plus  = idx_ext + link_t'(1);

  // A rebuild chains nodes 0 .. len-1; every other node gets no links.
  assign chain_prev = (idx_ext < len_q && idx_q != '0) ? link_t'(idx_t'(idx_q - 1'b1)) : NoNode;
  assign chain_next = (idx_plus < len_q) ? idx_plus : NoNode;
  assign cfg_len_clip = (cfg_len_q > NoNode) ? NoNode : cfg_len_q;

  // Condition select for the sequencer's conditional jumps.
  always_comb begin
    case (uc.cond)
      C_ALWAYS:    cond_raw = 1'b1;
      C_EMPTY_H:   cond_raw = (cnt_q == '0) || !in_pool(head_q);
      C_EMPTY_T:   cond_raw = (cnt_q == '0) || !in_pool(tail_q);
      C_HEAD_EQ_N: cond_raw = (head_q == node_ext);
      C_TAIL_EQ_N: cond_raw = (tail_q == node_ext);
      C_P_IN:      cond_raw = in_pool(rdp);
      C_X_IN:      cond_raw = in_pool(rdn);
      C_CNT_ZERO:  cond_raw = (cnt_q == '0);
      C_IS_MOVE:   cond_raw = (cmd_q == CMD_MOVE_HEAD) || (cmd_q == CMD_MOVE_TAIL);
      C_MOVE_HEAD: cond_raw = (cmd_q == CMD_MOVE_HEAD);
      C_IDX_LAST:  cond_raw = (idx_q == idx_t'(NodeCount - 1));
      C_INIT:      cond_raw = init_q;
      default:     cond_raw = 1'b0;
    endcase
  end

  assign take_jump = cond_raw ^ uc.cond_inv;

  // Step counter: dispatch on a new request, wait for the output slot, or run the program.
  always_comb begin
    step_d     = step_q;
    in_accept  = 1'b0;
    resp_fire  = 1'b0;
    in_ready_o = 1'b0;
    case (uc.kind)
      K_DISPATCH: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_accept = 1'b1;
          step_d    = dispatch(cmd_e'(command_i), in_pool(link_t'(node_index_i)));
        end
      end
      K_RESPOND: begin
        if (!out_valid_q || out_ready_i) begin
          resp_fire = 1'b1;
          step_d    = S_IDLE;
        end
      end
      K_RUN: begin
        step_d = take_jump ? uc.target : step_t'(step_q + 1'b1);
      end
      default: begin
        step_d = S_IDLE;
      end
    endcase
  end

  // Read address for the registered link read.
  always_comb begin
    case (uc.rsel)
      RS_NODE: rd_addr = node_q;
      RS_HEAD: rd_addr = head_q[IdxW-1:0];
      RS_TAIL: rd_addr = tail_q[IdxW-1:0];
      default: rd_addr = node_q;
    endcase
  end

  // Write address and data for the previous-link memory.
  always_comb begin
    case (uc.prev_wa)
      WA_NODE: prev_waddr = node_ext;
      WA_HEAD: prev_waddr = head_q;
      WA_TAIL: prev_waddr = tail_q;
      WA_RDP:  prev_waddr = rdp;
      WA_RDN:  prev_waddr = rdn;
      WA_IDX:  prev_waddr = idx_ext;
      default: prev_waddr = node_ext;
    endcase
    case (uc.prev_wd)
      WD_NONE:  prev_wr.data = NoNode;
      WD_NODE:  prev_wr.data = node_ext;
      WD_HEAD:  prev_wr.data = head_q;
      WD_TAIL:  prev_wr.data = tail_q;
      WD_RDP:   prev_wr.data = rdp;
      WD_RDN:   prev_wr.data = rdn;
      WD_CHAIN: prev_wr.data = chain_prev;
      default:  prev_wr.data = NoNode;
    endcase
    prev_wr.we   = uc.prev_we;
    prev_wr.addr = prev_waddr[IdxW-1:0];
  end

  // Write address and data for the next-link memory.
  always_comb begin
    case (uc.next_wa)
      WA_NODE: next_waddr = node_ext;
      WA_HEAD: next_waddr = head_q;
      WA_TAIL: next_waddr = tail_q;
      WA_RDP:  next_waddr = rdp;
      WA_RDN:  next_waddr = rdn;
      WA_IDX:  next_waddr = idx_ext;
      default: next_waddr = node_ext;
    endcase
    case (uc.next_wd)
      WD_NONE:  next_wr.data = NoNode;
      WD_NODE:  next_wr.data = node_ext;
      WD_HEAD:  next_wr.data = head_q;
      WD_TAIL:  next_wr.data = tail_q;
      WD_RDP:   next_wr.data = rdp;
      WD_RDN:   next_wr.data = rdn;
      WD_CHAIN: next_wr.data = chain_next;
      default:  next_wr.data = NoNode;
    endcase
    next_wr.we   = uc.next_we;
    next_wr.addr = next_waddr[IdxW-1:0];
  end

  // Head, tail and length updates.
  always_comb begin
    case (uc.head_sel)
      PS_KEEP:  head_d = head_q;
      PS_NODE:  head_d = node_ext;
      PS_RDP:   head_d = rdp;
      PS_RDN:   head_d = rdn;
      PS_NONE:  head_d = NoNode;
      PS_CHAIN: head_d = (len_q == '0) ? NoNode : '0;
      default:  head_d = head_q;
    endcase
    case (uc.tail_sel)
      PS_KEEP:  tail_d = tail_q;
      PS_NODE:  tail_d = node_ext;
      PS_RDP:   tail_d = rdp;
      PS_RDN:   tail_d = rdn;
      PS_NONE:  tail_d = NoNode;
      PS_CHAIN: tail_d = (len_q == '0) ? NoNode : link_t'(len_q - 1'b1);
      default:  tail_d = tail_q;
    endcase
    case (uc.cnt_op)
      CNT_KEEP: cnt_d = cnt_q;
      CNT_INC:  cnt_d = (cnt_q < NoNode) ? link_t'(cnt_q + 1'b1) : cnt_q;
      CNT_DEC:  cnt_d = (cnt_q != '0) ? link_t'(cnt_q - 1'b1) : cnt_q;
      CNT_LOAD: cnt_d = len_q;
      default:  cnt_d = cnt_q;
    endcase
  end

  idll_link_mem u_link_mem (
    .clk_i     (clk_i),
    .prev_wr_i (prev_wr),
    .next_wr_i (next_wr),
    .rd_en_i   (uc.rd_en),
    .rd_addr_i (rd_addr),
    .prev_rd_o (rdp),
    .next_rd_o (rdn)
  );

  // Control and list state. Reset starts the sequencer on the rebuild program with an
  // empty chain, which sets every link to "no node".
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= S_RB0;
      init_q    <= 1'b1;
      cfg_len_q <= '0;
      head_q    <= NoNode;
      tail_q    <= NoNode;
      cnt_q     <= '0;
    end else begin
      step_q <= step_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      if (uc.init_clr) begin
        init_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        cfg_len_q <= initial_length_i;
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= cmd_e'(command_i);
      node_q   <= node_index_i;
      status_q <= 1'b0;
      pop_q    <= '0;
      popv_q   <= 1'b0;
    end else begin
      if (uc.st_set) begin
        status_q <= 1'b1;
      end
      case (uc.pop_sel)
        POP_HEAD: begin
          pop_q  <= head_q[IdxW-1:0];
          popv_q <= 1'b1;
        end
        POP_TAIL: begin
          pop_q  <= tail_q[IdxW-1:0];
          popv_q <= 1'b1;
        end
        default: begin
          pop_q  <= pop_q;
          popv_q <= popv_q;
        end
      endcase
    end
    // The reset sweep always builds an empty chain, whatever is being configured.
    if (uc.rb_start) begin
      len_q <= init_q ? '0 : cfg_len_clip;
      idx_q <= '0;
    end else if (uc.idx_inc) begin
      idx_q <= idx_t'(idx_q + 1'b1);
    end
  end

  // Output register: a result waits here while the next request is under way.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_fire) begin
      out_status_q <= status_q;
      out_pop_q    <= pop_q;
      out_popv_q   <= popv_q;
      out_len_q    <= cnt_q;
      out_head_q   <= head_q;
      out_tail_q   <= tail_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign popped_node_o  = out_pop_q;
  assign popped_valid_o = out_popv_q;
  assign list_length_o  = out_len_q;
  assign head_node_o    = out_head_q;
  assign tail_node_o    = out_tail_q;
  assign cfg_ready_o    = 1'b1;

endmodule

### rtl/core/idll_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the indexed doubly linked list, bound to the top level.
// Depends on idll_pkg and indexed_doubly_linked_list.

module idll_checker import idll_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input logic  status_o,
  input idx_t  popped_node_o,
  input logic  popped_valid_o,
  input link_t list_length_o,
  input link_t head_node_o,
  input link_t tail_node_o
);

  // A successful pop always shortens the list, so it cannot report full length.
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && popped_valid_o |-> !status_o && (list_length_o < NoNode))
    else $error("pop result with empty status or full length");

  a_no_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !popped_valid_o |-> popped_node_o == '0)
    else $error("popped node set without a pop");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> list_length_o <= NoNode)
    else $error("list length above pool size");

  // Requests are worked one at a time.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(list_length_o) &&
      $stable(head_node_o) && $stable(tail_node_o))
    else $error("stalled result changed");

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .popped_node_o  (popped_node_o),
  .popped_valid_o (popped_valid_o),
  .list_length_o  (list_length_o),
  .head_node_o    (head_node_o),
  .tail_node_o    (tail_node_o)
);

### sim/indexed_doubly_linked_list_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_doubly_linked_list: a short scripted run, then
// random list traffic checked against a behavioral model kept inside the bench.
// Depends on idll_pkg and the RTL of the block; reads no files.

module indexed_doubly_linked_list_tb import idll_pkg::*; ();

  // Status values carried by a result.
  localparam logic StDone  = 1'b0;
  localparam logic StEmpty = 1'b1;

  // Everything the block reports for one request.
  typedef struct packed {
    logic  status;
    idx_t  popped;
    logic  popped_valid;
    link_t length;
    link_t head;
    link_t tail;
  } list_view_t;

  // One line of the scripted part: either a register write or a request. A request
  // whose outcome is obvious carries its result inline; the others go through the model.
  typedef struct {
    bit         is_cfg;
    link_t      cfg_value;
    cmd_e       cmd;
    idx_t       node;
    bit         typed;
    list_view_t view;
  } script_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] command = CMD_PUSH_HEAD;
  idx_t       node_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       status;
  idx_t       popped_node;
  logic       popped_valid;
  link_t      list_length;
  link_t      head_node;
  link_t      tail_node;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  link_t      initial_length = '0;

  indexed_doubly_linked_list DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (command),
    .node_index_i     (node_index),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .popped_node_o    (popped_node),
    .popped_valid_o   (popped_valid),
    .list_length_o    (list_length),
    .head_node_o      (head_node),
    .tail_node_o      (tail_node),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .initial_length_i (initial_length)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Behavioral model of the list. The link arrays, the end pointers and the length
  // mirror the block's state; the chain length register mirrors its configuration.
  // ---------------------------------------------------------------------------
  link_t prev_of [NodeCount];
  link_t next_of [NodeCount];
  link_t first_node;
  link_t last_node;
  link_t node_total;
  link_t chain_length;

  // Nodes the stimulus believes are on the list. This only steers the generator
  // toward consistent traffic; it is never used for checking.
  bit on_list [NodeCount];

  // Results predicted for accepted requests, oldest first.
  list_view_t awaited_results[$];

  int error_count = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int rebuilds_sent = 0;
  int pops_seen = 0;
  int empties_seen = 0;

  function automatic bit is_node(link_t x);
    return x < link_t'(NodeCount);
  endfunction

  // Chains nodes 0 .. chain_length-1 in order, capped at the pool size, and clears every other link.
  function automatic void rechain();
    int count;
    count = (chain_length > link_t'(NodeCount)) ? NodeCount : int'(chain_length);
    for (int i = 0; i < NodeCount; i++) begin
      if (i < count) begin
        prev_of[i] = (i == 0) ? NoNode : link_t'(i - 1);
        next_of[i] = (i + 1 < count) ? link_t'(i + 1) : NoNode;
      end else begin
        prev_of[i] = NoNode;
        next_of[i] = NoNode;
      end
    end
    node_total = link_t'(count);
    first_node = (count == 0) ? NoNode : link_t'(0);
    last_node  = (count == 0) ? NoNode : link_t'(count - 1);
  endfunction

  // Links node n in at one end. A node that already sits at that end is left alone,
  // and the length never goes past the pool size.
  function automatic void link_at_end(idx_t n, bit at_head);
    link_t end_node;
    end_node = at_head ? first_node : last_node;
    if (node_total == 0 || !is_node(end_node)) begin
      prev_of[n] = NoNode;
      next_of[n] = NoNode;
      first_node = link_t'(n);
      last_node  = link_t'(n);
    end else begin
      if (end_node == link_t'(n)) return;
      if (at_head) begin
        prev_of[n] = NoNode;
        prev_of[end_node[IdxW-1:0]] = link_t'(n);
        next_of[n] = end_node;
        first_node = link_t'(n);
      end else begin
        next_of[n] = NoNode;
        next_of[end_node[IdxW-1:0]] = link_t'(n);
        prev_of[n] = end_node;
        last_node = link_t'(n);
      end
    end
    if (node_total < link_t'(NodeCount)) node_total++;
  endfunction

  // Takes node n out by bridging its neighbors. Returns 1 when the list was empty,
  // in which case nothing is touched. Membership is not checked, as in the block.
  function automatic bit unlink_node(idx_t n);
    link_t p;
    link_t x;
    if (node_total == 0) return 1'b1;
    p = prev_of[n];
    x = next_of[n];
    if (is_node(p)) next_of[p[IdxW-1:0]] = x;
    else first_node = is_node(x) ? x : NoNode;
    if (is_node(x)) prev_of[x[IdxW-1:0]] = p;
    else last_node = is_node(p) ? p : NoNode;
    node_total--;
    return 1'b0;
  endfunction

  // Applies one command to the model and returns what the block should report.
  function automatic list_view_t apply_list_command(cmd_e cmd, idx_t n);
    list_view_t v;
    link_t      taken;
    link_t      neighbor;
    bit         at_head;
    v = '0;
    case (cmd)
      CMD_POP_HEAD, CMD_POP_TAIL: begin
        at_head = (cmd == CMD_POP_HEAD);
        taken = at_head ? first_node : last_node;
        if (node_total == 0 || !is_node(taken)) begin
          v.status = StEmpty;
        end else begin
          neighbor = at_head ? next_of[taken[IdxW-1:0]] : prev_of[taken[IdxW-1:0]];
          if (is_node(neighbor)) begin
            if (at_head) begin
              prev_of[neighbor[IdxW-1:0]] = NoNode;
              first_node = neighbor;
            end else begin
              next_of[neighbor[IdxW-1:0]] = NoNode;
              last_node = neighbor;
            end
          end else begin
            first_node = NoNode;
            last_node = NoNode;
          end
          node_total--;
          v.popped = taken[IdxW-1:0];
          v.popped_valid = 1'b1;
        end
      end
      CMD_REBUILD: rechain();
      CMD_PUSH_HEAD, CMD_PUSH_TAIL: link_at_end(n, cmd == CMD_PUSH_HEAD);
      CMD_REMOVE: v.status = unlink_node(n) ? StEmpty : StDone;
      default: begin
        // A move is a remove followed by a push; the push runs even when the list
        // was empty, so the node ends up as the only element.
        v.status = unlink_node(n) ? StEmpty : StDone;
        link_at_end(n, cmd == CMD_MOVE_HEAD);
      end
    endcase
    v.length = node_total;
    v.head = first_node;
    v.tail = last_node;
    return v;
  endfunction

  // Keeps the generator's idea of list membership in step with what was sent.
  function automatic void track_membership(cmd_e cmd, idx_t n, list_view_t v);
    case (cmd)
      CMD_POP_HEAD, CMD_POP_TAIL: if (v.popped_valid) on_list[v.popped] = 1'b0;
      CMD_REMOVE: on_list[n] = 1'b0;
      CMD_REBUILD: for (int i = 0; i < NodeCount; i++) on_list[i] = (i < int'(v.length));
      default: on_list[n] = 1'b1;
    endcase
  endfunction

  // Looks for a node whose membership matches want, starting at a random place.
  function automatic bit find_node(bit want, output idx_t n);
    int start;
    start = $urandom_range(0, NodeCount - 1);
    n = '0;
    for (int k = 0; k < NodeCount; k++) begin
      n = idx_t'((start + k) % NodeCount);
      if (on_list[n] == want) return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. All drives are nonblocking at a rising edge. The request task
  // raises valid and leaves it high when it returns, so that back-to-back requests
  // never lower and raise valid within one time step; only the callers lower it.
  // ---------------------------------------------------------------------------
  task automatic send_request(cmd_e cmd, idx_t n, bit typed, list_view_t typed_view);
    list_view_t v;
    in_valid <= 1'b1;
    command <= cmd;
    node_index <= n;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    // The request was taken at this edge: predict its result now.
    v = apply_list_command(cmd, n);
    awaited_results.push_back(typed ? typed_view : v);
    track_membership(cmd, n, v);
    requests_sent++;
    if (cmd == CMD_REBUILD) rebuilds_sent++;
  endtask

  // Lowers valid and waits until every predicted result has come back. It always waits
  // on the clock first, so a request that follows never shares its time step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // The register is only written with no request in flight.
  task automatic write_chain_length(link_t value);
    drain_results();
    cfg_valid <= 1'b1;
    initial_length <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    chain_length = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every accepted result against the oldest prediction, then
  // pick the next value of ready. Ready follows windows of random length, each
  // with its own behavior: always ready, mostly ready, mostly stalled, or a long
  // stall that ends in a ready stretch.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    list_view_t got;
    list_view_t want;
    got = '{status, popped_node, popped_valid, list_length, head_node, tail_node};
    if (out_valid && out_ready) begin
      results_seen++;
      if (got.popped_valid) pops_seen++;
      if (got.status == StEmpty) empties_seen++;
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result with nothing outstanding: st=%0d pop=%0d/%0d len=%0d h=%0d t=%0d",
                   $realtime, got.status, got.popped_valid, got.popped, got.length,
                   got.head, got.tail);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: result %0d mismatch", $realtime, results_seen);
            $display("  want st=%0d pop=%0d/%0d len=%0d h=%0d t=%0d", want.status,
                     want.popped_valid, want.popped, want.length, want.head, want.tail);
            $display("  got  st=%0d pop=%0d/%0d len=%0d h=%0d t=%0d", got.status,
                     got.popped_valid, got.popped, got.length, got.head, got.tail);
          end
        end
      end
    end

    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_left < 24);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Scripted part. Rows build up and tear down a small list, exercise every
  // command, the pushes that change nothing, the empty-list reports, a move on an
  // empty list, an oversized chain length, saturation of a full list, and a
  // remove of a node that is not on the list.
  // ---------------------------------------------------------------------------
  script_row_t script[$];

  function automatic script_row_t cfg_row(link_t value);
    script_row_t r;
    r = '{is_cfg: 1'b1, cfg_value: value, cmd: CMD_REBUILD, node: '0, typed: 1'b0, view: '0};
    return r;
  endfunction

  function automatic script_row_t model_row(cmd_e cmd, idx_t n);
    script_row_t r;
    r = '{is_cfg: 1'b0, cfg_value: '0, cmd: cmd, node: n, typed: 1'b0, view: '0};
    return r;
  endfunction

  function automatic script_row_t known_row(cmd_e cmd, idx_t n, logic st, logic pv, idx_t pop,
                                            link_t len, link_t head, link_t tail);
    script_row_t r;
    r = '{is_cfg: 1'b0, cfg_value: '0, cmd: cmd, node: n, typed: 1'b1,
          view: '{st, pop, pv, len, head, tail}};
    return r;
  endfunction

  // Draws one random request. Most traffic keeps membership consistent (pushes of
  // nodes off the list, removes and moves of nodes on it); the rest is random noise
  // and the odd rebuild, which also brings a damaged list back into shape.
  task automatic pick_random_request(output cmd_e cmd, output idx_t n);
    int  roll;
    int  grow;
    bit  found;
    roll = $urandom_range(0, 99);
    n = idx_t'($urandom);
    if (roll < 2) begin
      cmd = CMD_REBUILD;
    end else if (roll < 14) begin
      cmd = cmd_e'($urandom_range(0, 6));
    end else begin
      grow = (node_total < 4) ? 70 : ((node_total > 200) ? 20 : 45);
      roll = $urandom_range(0, 99);
      if (roll < grow) begin
        found = find_node(1'b0, n);
        cmd = $urandom_range(0, 1) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
        if (!found) cmd = $urandom_range(0, 1) ? CMD_POP_HEAD : CMD_POP_TAIL;
      end else if (roll < grow + (100 - grow) / 3) begin
        cmd = $urandom_range(0, 1) ? CMD_POP_HEAD : CMD_POP_TAIL;
      end else begin
        found = find_node(1'b1, n);
        cmd = cmd_e'($urandom_range(CMD_REMOVE, CMD_MOVE_TAIL));
        if (!found) cmd = $urandom_range(0, 1) ? CMD_POP_HEAD : CMD_POP_TAIL;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    cmd_e  cmd;
    idx_t  n;
    int    burst_left;
    int    gap;
    link_t phase_length;

    chain_length = '0;
    rechain();
    for (int i = 0; i < NodeCount; i++) on_list[i] = 1'b0;

    script.push_back(known_row(CMD_POP_HEAD, 8'h00, StEmpty, 0, 0, 0, NoNode, NoNode));
    script.push_back(known_row(CMD_POP_TAIL, 8'hFF, StEmpty, 0, 0, 0, NoNode, NoNode));
    script.push_back(known_row(CMD_REMOVE, 8'hAA, StEmpty, 0, 0, 0, NoNode, NoNode));
    script.push_back(known_row(CMD_MOVE_HEAD, 8'hFF, StEmpty, 0, 0, 1, 9'd255, 9'd255));
    script.push_back(known_row(CMD_PUSH_HEAD, 8'hFF, StDone, 0, 0, 1, 9'd255, 9'd255));
    script.push_back(model_row(CMD_PUSH_TAIL, 8'h00));
    script.push_back(model_row(CMD_PUSH_TAIL, 8'h00));
    script.push_back(model_row(CMD_PUSH_HEAD, 8'h55));
    script.push_back(model_row(CMD_PUSH_TAIL, 8'hAA));
    script.push_back(model_row(CMD_MOVE_TAIL, 8'h55));
    script.push_back(model_row(CMD_MOVE_HEAD, 8'h00));
    script.push_back(model_row(CMD_REMOVE, 8'hFF));
    script.push_back(model_row(CMD_POP_HEAD, 8'h00));
    script.push_back(model_row(CMD_POP_TAIL, 8'h00));
    script.push_back(cfg_row(9'd511));
    script.push_back(known_row(CMD_REBUILD, 8'h00, StDone, 0, 0, 9'd256, 9'd0, 9'd255));
    script.push_back(model_row(CMD_PUSH_HEAD, 8'h07));
    script.push_back(model_row(CMD_POP_TAIL, 8'h00));
    script.push_back(cfg_row(9'd0));
    script.push_back(known_row(CMD_REBUILD, 8'hFF, StDone, 0, 0, 0, NoNode, NoNode));
    script.push_back(cfg_row(9'd256));
    script.push_back(known_row(CMD_REBUILD, 8'h00, StDone, 0, 0, 9'd256, 9'd0, 9'd255));
    script.push_back(cfg_row(9'd1));
    script.push_back(known_row(CMD_REBUILD, 8'h00, StDone, 0, 0, 1, 9'd0, 9'd0));
    script.push_back(known_row(CMD_POP_HEAD, 8'h00, StDone, 1, 0, 0, NoNode, NoNode));
    script.push_back(known_row(CMD_MOVE_TAIL, 8'h80, StEmpty, 0, 0, 1, 9'd128, 9'd128));
    script.push_back(model_row(CMD_REMOVE, 8'hC8));

    // Hold reset, then release it. The block then clears its link memories and holds off
    // requests until done; the first request simply waits for ready.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_chain_length(script[i].cfg_value);
      else send_request(script[i].cmd, script[i].node, script[i].typed, script[i].view);
    end

    // Random part: six phases, each with its own chain length and an opening rebuild.
    // The lengths cover small lists, an empty chain, oversized values and the rest.
    burst_left = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: phase_length = link_t'($urandom_range(2, 12));
        1: phase_length = link_t'($urandom_range(257, 511));
        2: phase_length = '0;
        3: phase_length = link_t'($urandom_range(0, 511));
        4: phase_length = link_t'($urandom_range(20, 60));
        default: phase_length = link_t'($urandom_range(1, 8));
      endcase
      write_chain_length(phase_length);
      send_request(CMD_REBUILD, idx_t'($urandom), 1'b0, '0);
      for (int k = 0; k < 100; k++) begin
        // The sender runs in bursts; between bursts it either may idle with valid low
        // or, now and then, waits until every outstanding result is back.
        if (burst_left == 0) begin
          gap = $urandom_range(0, 6);
          if ($urandom_range(0, 19) == 0) begin
            drain_results();
          end else if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10);
        end
        burst_left--;
        pick_random_request(cmd, n);
        send_request(cmd, n, 1'b0, '0);
      end
    end

    // Let the last results come back, then wait on for anything stray.
    drain_results();
    repeat (32) @(posedge clk_i);

    $display("Sent %0d requests (%0d rebuilds) and checked %0d results.",
             requests_sent, rebuilds_sent, results_seen);
    $display("Results included %0d pops that returned a node and %0d empty-list reports.",
             pops_seen, empties_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: many times the length of the slowest correct run.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
